FILE: hdl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned TRIG_W  = 4;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned MAXD_W  = 11;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned REM_W   = 7;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CFG_W   = 16;

  // range in mm = (width*10 + 29) / 58, tracked as a running quotient and remainder
  localparam logic [REM_W-1:0] REM_FIRST = 7'd39;
  localparam logic [REM_W-1:0] REM_STEP  = 7'd10;
  localparam logic [REM_W-1:0] DIVISOR   = 7'd58;

  localparam logic [CNT_W-1:0]  TIMEOUT_RST = 16'd30000;
  localparam logic [MAXD_W-1:0] MAXD_RST    = 11'd400;

  localparam logic [IDX_W-1:0] REG_TIMEOUT  = 8'd0;
  localparam logic [IDX_W-1:0] REG_MAX_DIST = 8'd1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_ABOVE   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TRIG  = 2'd1,
    PH_WAIT  = 2'd2,
    PH_WIDTH = 2'd3
  } phase_t;

  // sequencer to distance tracker
  typedef struct packed {
    logic load;
    logic step;
  } dist_ctl_t;

  // sequencer result flags for one item
  typedef struct packed {
    logic trig;
    logic done;
    logic timeout;
    logic finish;
  } res_ctl_t;

endpackage

FILE: hdl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement sequencer: trigger pulse, echo wait and echo width countdowns.
// ----------------------------------------------------------------------------
module uer_ctrl #(
  parameter int unsigned TRIG_TICKS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       op,
  input  logic                       echo_level,
  input  logic [uer_pkg::CNT_W-1:0]  timeout_ticks,
  output uer_pkg::dist_ctl_t         dist_ctl,
  output uer_pkg::res_ctl_t          res_ctl
);
  import uer_pkg::*;

  localparam logic [TRIG_W-1:0] TRIG_LOAD = TRIG_W'(TRIG_TICKS);

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    countdown_r, countdown_nxt;
  logic [TRIG_W-1:0]   trig_cnt_r, trig_cnt_nxt;
  logic [TRIG_W-1:0]   trig_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      countdown_r <= '0;
      trig_cnt_r  <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      countdown_r <= countdown_nxt;
      trig_cnt_r  <= trig_cnt_nxt;
    end
  end

  assign trig_dec = (trig_cnt_r != '0) ? trig_cnt_r - TRIG_W'(1) : trig_cnt_r;

  always_comb begin
    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    trig_cnt_nxt  = trig_cnt_r;
    dist_ctl      = '0;
    res_ctl       = '0;
    if (op == OP_START) begin
      phase_nxt     = PH_TRIG;
      trig_cnt_nxt  = TRIG_LOAD;
      countdown_nxt = '0;
      res_ctl.trig  = 1'b1;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_TRIG: begin
          trig_cnt_nxt = trig_dec;
          if (trig_dec == '0) begin
            phase_nxt     = PH_WAIT;
            countdown_nxt = timeout_ticks;
          end else begin
            res_ctl.trig = 1'b1;
          end
        end
        PH_WAIT: begin
          if (echo_level) begin
            dist_ctl.load = 1'b1;
            if (timeout_ticks <= CNT_W'(1)) begin
              phase_nxt       = PH_IDLE;
              countdown_nxt   = '0;
              res_ctl.done    = 1'b1;
              res_ctl.timeout = 1'b1;
            end else begin
              phase_nxt     = PH_WIDTH;
              countdown_nxt = timeout_ticks - CNT_W'(1);
            end
          end else if (countdown_r <= CNT_W'(1)) begin
            phase_nxt       = PH_IDLE;
            countdown_nxt   = '0;
            res_ctl.done    = 1'b1;
            res_ctl.timeout = 1'b1;
          end else begin
            countdown_nxt = countdown_r - CNT_W'(1);
          end
        end
        PH_WIDTH: begin
          if (echo_level) begin
            dist_ctl.step = 1'b1;
            if (countdown_r <= CNT_W'(1)) begin
              phase_nxt       = PH_IDLE;
              countdown_nxt   = '0;
              res_ctl.done    = 1'b1;
              res_ctl.timeout = 1'b1;
            end else begin
              countdown_nxt = countdown_r - CNT_W'(1);
            end
          end else begin
            phase_nxt      = PH_IDLE;
            res_ctl.done   = 1'b1;
            res_ctl.finish = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/uer_dist.sv
// ----------------------------------------------------------------------------
// uer_dist
// Running distance in mm over the echo width, with the range limit check.
// ----------------------------------------------------------------------------
module uer_dist (
  input  logic                        clk,
  input  logic                        accept,
  input  uer_pkg::dist_ctl_t          dist_ctl,
  input  logic [uer_pkg::MAXD_W-1:0]  max_distance_cm,
  output logic [uer_pkg::DIST_W-1:0]  dist_mm,
  output logic                        above
);
  import uer_pkg::*;

  logic [DIST_W-1:0]  quo_r, quo_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [REM_W-1:0]   rem_sum;
  logic [LIMIT_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (accept) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rem_sum = rem_r + REM_STEP;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (dist_ctl.load) begin
      quo_nxt = '0;
      rem_nxt = REM_FIRST;
    end else if (dist_ctl.step) begin
      if (rem_sum >= DIVISOR) begin
        quo_nxt = quo_r + DIST_W'(1);
        rem_nxt = rem_sum - DIVISOR;
      end else begin
        rem_nxt = rem_sum;
      end
    end
  end

  // max_distance_cm * 10
  assign limit   = {1'b0, max_distance_cm, 3'b000} + {3'b000, max_distance_cm, 1'b0};
  assign dist_mm = quo_r;
  assign above   = LIMIT_W'(quo_r) > limit;

endmodule

FILE: hdl/ultrasonic_echo_ranger_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top
// Ultrasonic ranger: trigger pulse, echo timing and distance in millimeters.
// ----------------------------------------------------------------------------
// Input items arrive on the in_ stream: in_tuser carries op (start or one
// microsecond tick), in_tdata carries the sampled echo level. Every input
// item gives exactly one result item on the out_ stream with the trigger
// pin level, the done flag, the distance and the status.
// Registers are written on the cfg_ channel (index 0 timeout_ticks, index 1
// max_distance_cm); cfg_ready is always high, other indexes are ignored.
// The result is registered and shows in the cycle after its input item;
// one item is taken every cycle while in_tready is high, set by the
// sequencer and the running quotient update of the distance tracker.
// The result sits in an output register; a new item is taken while it is
// being delivered, and in_tready drops only while out_tvalid is high and
// out_tready is low.
// Reset (rst_n low, synchronous) returns to idle, empties the output
// register and loads the register defaults (30000 ticks, 400 cm).
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top #(
  parameter int unsigned TRIG_TICKS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [0] echo_level
  input  logic                       in_tuser,   // [0] op
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,  // [0] trig_out, [14:1] range_mm, [16:15] status
  output logic                       out_tuser,  // [0] done_res
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [uer_pkg::IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_W-1:0]  cfg_data
);
  import uer_pkg::*;

  logic [CNT_W-1:0]  timeout_r;
  logic [MAXD_W-1:0] max_dist_r;
  logic              accept;
  dist_ctl_t         dist_ctl;
  res_ctl_t          res_ctl;
  logic [DIST_W-1:0] dist_mm;
  logic              above;
  logic              out_valid_r;
  logic              trig_r;
  logic              done_r;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [1:0]        status_r, status_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      max_dist_r <= MAXD_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TIMEOUT) begin
        timeout_r <= cfg_data;
      end
      if (cfg_index == REG_MAX_DIST) begin
        max_dist_r <= cfg_data[MAXD_W-1:0];
      end
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  uer_ctrl #(
    .TRIG_TICKS(TRIG_TICKS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .op           (in_tuser),
    .echo_level   (in_tdata[0]),
    .timeout_ticks(timeout_r),
    .dist_ctl     (dist_ctl),
    .res_ctl      (res_ctl)
  );

  uer_dist u_dist (
    .clk            (clk),
    .accept         (accept),
    .dist_ctl       (dist_ctl),
    .max_distance_cm(max_dist_r),
    .dist_mm        (dist_mm),
    .above          (above)
  );

  always_comb begin
    dist_nxt   = '0;
    status_nxt = ST_OK;
    if (res_ctl.timeout) begin
      status_nxt = ST_TIMEOUT;
    end else if (res_ctl.finish) begin
      dist_nxt   = dist_mm;
      status_nxt = above ? ST_ABOVE : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trig_r   <= res_ctl.trig;
      done_r   <= res_ctl.done;
      dist_r   <= dist_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, status_r, dist_r, trig_r};
  assign out_tuser  = done_r;

endmodule
